// ===== rtl/hwt_pkg.sv =====
// hwt_pkg: types and constants for the hermite waypoint trajectory generator
// no dependencies; imported by hermite_waypoint_trajectory

package hwt_pkg;

    localparam int Q_W        = 24;
    localparam int IDX_W      = 7;
    localparam int PHASE_W    = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam int COEF_W     = 24;
    localparam int PROD_W     = 49;
    localparam int ACC_W      = 50;
    localparam int DIV_W      = 25;
    localparam int QUO_W      = 24;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int SEQ_CNT_W  = 3;

    localparam logic [SEQ_CNT_W-1:0] FETCH_LAST = 3'd4;
    localparam logic [SEQ_CNT_W-1:0] MAC_LAST   = 3'd4;
    localparam logic [SEQ_CNT_W-1:0] MAC_SUB    = 3'd3;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST  = 8'd1;

    localparam logic [PHASE_W-1:0] TICKS_RESET = 8'd10;
    localparam logic [IDX_W-1:0]   LAST_RESET  = 7'd100;

    localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

    typedef struct packed {
        logic [1:0]              req_type;
        logic                    load_axis;
        logic [IDX_W-1:0]        load_index;
        logic signed [Q_W-1:0]   load_position;
        logic signed [Q_W-1:0]   load_velocity;
    } in_word_t;

    typedef struct packed {
        logic signed [Q_W-1:0]   shoulder_command;
        logic signed [Q_W-1:0]   elbow_command;
        logic                    done_res;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SQUARE,
        ST_COEF,
        ST_MAC,
        ST_DIVSET,
        ST_DIVCHK,
        ST_DIV,
        ST_FINISH,
        ST_PUT
    } state_t;

endpackage

// ===== rtl/hermite_waypoint_trajectory.sv =====
// hermite_waypoint_trajectory: two-axis cubic hermite trajectory generator
// depends on hwt_pkg (word types, request and register codes, state type)
//
// input words on s_valid/s_ready: load a waypoint, start, or tick. results on
// m_valid/m_ready, one word per tick while running. registers are written on
// cfg_valid/cfg_ready (index 0 ticks per segment, 1 last waypoint index).
// a tick inside a segment runs the squares, the coefficients, the
// multiply-accumulate (both axes side by side) and the divider (two quotient
// bits a cycle); a tick that opens a new segment first reads its ends (four
// reads of the single read port of the waypoint memory). the final tick, with
// done set, skips the arithmetic. no new word is accepted while a tick runs.
// the result sits in an output register; while the receiver stalls the next
// word is still accepted, and a finished result waits until the output
// register is free. reset sets the registers to 10 ticks and last index 100,
// clears the phase, the segment index and the latched segment ends and leaves
// the block idle; the waypoint memory keeps its contents, undefined until loaded.

module hermite_waypoint_trajectory
    import hwt_pkg::*;
#(
    parameter int MAX_POINTS = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = 2 * MAX_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MEM_W  = 2 * Q_W;

    state_t state_reg, state_next;

    logic [PHASE_W-1:0] ticks_reg;
    logic [IDX_W-1:0]   last_reg;
    logic               running_reg;
    logic [IDX_W-1:0]   seg_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [SEQ_CNT_W-1:0] fetch_cnt_reg;
    logic [SEQ_CNT_W-1:0] mac_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic [MEM_W-1:0]   mem [DEPTH];
    logic [MEM_W-1:0]   rd_data_reg;
    logic               rd_ok_reg;
    logic [1:0]         rd_sel_reg;

    logic signed [Q_W-1:0] p0_reg [2];
    logic signed [Q_W-1:0] p1_reg [2];
    logic signed [Q_W-1:0] v0_reg [2];
    logic signed [Q_W-1:0] v1_reg [2];

    logic [PHASE_W-1:0] n_reg, k_reg;
    logic [15:0]        msq_reg, ksq_reg, nsq_reg;
    logic [COEF_W-1:0]  c_reg [4];
    logic [COEF_W-1:0]  den_reg;

    logic signed [PROD_W-1:0] prod_reg [2];
    logic                     prod_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg [2];
    logic [ACC_W-1:0]         x_reg [2];
    logic                     neg_reg [2];
    logic                     ovf_reg [2];
    logic [DIV_W-1:0]         rem_reg [2];
    logic [QUO_W-1:0]         quo_reg [2];
    logic [DIV_W-1:0]         rem_next [2];
    logic [QUO_W-1:0]         quo_next [2];

    out_word_t res_reg;
    out_word_t m_data_reg;
    logic      m_valid_reg;

    logic               s_fire;
    logic               tick_go;
    logic               can_latch;
    logic [PHASE_W-1:0] n_cur, k_cur, phase_adv;
    logic [PHASE_W:0]   k_inc;
    logic               load_ok;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [IDX_W-1:0]   rd_idx;
    logic [PHASE_W-1:0] m_w;
    logic [9:0]         a0_w, a1_w;
    logic [DIV_W-1:0]   dvs_w;
    logic [COEF_W-1:0]  coef_sel;
    logic signed [Q_W-1:0] d_sel [2];
    logic signed [Q_W-1:0] cmd_sat [2];
    logic               out_free;

    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign cfg_ready = aresetn;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // phase and segment decode
    assign n_cur     = (ticks_reg == '0) ? 8'd1 : ticks_reg;
    assign k_cur     = (phase_reg >= n_cur) ? '0 : phase_reg;
    assign k_inc     = {1'b0, k_cur} + 9'd1;
    assign phase_adv = (k_inc >= {1'b0, n_cur}) ? '0 : k_inc[PHASE_W-1:0];
    assign tick_go   = s_fire && (s_data.req_type == REQ_TICK) && running_reg;
    assign can_latch = (seg_reg < last_reg);

    // waypoint memory addressing
    assign load_ok   = int'(s_data.load_index) < MAX_POINTS;
    assign mem_we    = s_fire && (s_data.req_type == REQ_LOAD) && load_ok;
    assign mem_waddr = s_data.load_axis
                     ? ADDR_W'(s_data.load_index) + ADDR_W'(MAX_POINTS)
                     : ADDR_W'(s_data.load_index);
    assign rd_idx    = seg_reg + {{(IDX_W-1){1'b0}}, fetch_cnt_reg[0]};
    assign mem_raddr = fetch_cnt_reg[1]
                     ? ADDR_W'(rd_idx) + ADDR_W'(MAX_POINTS)
                     : ADDR_W'(rd_idx);

    // coefficient terms
    assign m_w   = n_reg - k_reg;
    assign a0_w  = {2'b00, n_reg} + {1'b0, k_reg, 1'b0};
    assign a1_w  = {2'b00, n_reg} + {1'b0, n_reg, 1'b0} - {1'b0, k_reg, 1'b0};
    assign dvs_w = {den_reg, 1'b0};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_go) begin
                    if (k_cur != '0) begin
                        state_next = ST_SQUARE;
                    end else if (can_latch) begin
                        state_next = ST_FETCH;
                    end else begin
                        state_next = ST_PUT;
                    end
                end
            end
            ST_FETCH: begin
                if (fetch_cnt_reg == FETCH_LAST) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: state_next = ST_COEF;
            ST_COEF:   state_next = ST_MAC;
            ST_MAC: begin
                if (mac_cnt_reg == MAC_LAST) begin
                    state_next = ST_DIVSET;
                end
            end
            ST_DIVSET: state_next = ST_DIVCHK;
            ST_DIVCHK: state_next = ST_DIV;
            ST_DIV: begin
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_PUT;
            ST_PUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control state, registers and latched segment ends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg     <= TICKS_RESET;
            last_reg      <= LAST_RESET;
            running_reg   <= 1'b0;
            seg_reg       <= '0;
            phase_reg     <= '0;
            fetch_cnt_reg <= '0;
            mac_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
            for (int l = 0; l < 2; l++) begin
                p0_reg[l] <= '0;
                p1_reg[l] <= '0;
                v0_reg[l] <= '0;
                v1_reg[l] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TICKS: ticks_reg <= cfg_data;
                    CFG_LAST:  last_reg  <= cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end

            if (s_fire && (s_data.req_type == REQ_START)) begin
                running_reg <= 1'b1;
                seg_reg     <= '0;
                phase_reg   <= '0;
            end

            if (tick_go) begin
                if (k_cur == '0 && !can_latch) begin
                    running_reg <= 1'b0;
                    phase_reg   <= '0;
                end else begin
                    phase_reg <= phase_adv;
                end
            end

            if (state_reg == ST_FETCH) begin
                fetch_cnt_reg <= fetch_cnt_reg + 3'd1;
                if (fetch_cnt_reg == FETCH_LAST) begin
                    seg_reg <= seg_reg + 7'd1;
                end
                if (fetch_cnt_reg != '0) begin
                    case (rd_sel_reg)
                        2'd0: begin
                            p0_reg[0] <= rd_ok_reg ? rd_data_reg[MEM_W-1:Q_W] : '0;
                            v0_reg[0] <= rd_ok_reg ? rd_data_reg[Q_W-1:0] : '0;
                        end
                        2'd1: begin
                            p1_reg[0] <= rd_ok_reg ? rd_data_reg[MEM_W-1:Q_W] : '0;
                            v1_reg[0] <= rd_ok_reg ? rd_data_reg[Q_W-1:0] : '0;
                        end
                        2'd2: begin
                            p0_reg[1] <= rd_ok_reg ? rd_data_reg[MEM_W-1:Q_W] : '0;
                            v0_reg[1] <= rd_ok_reg ? rd_data_reg[Q_W-1:0] : '0;
                        end
                        default: begin
                            p1_reg[1] <= rd_ok_reg ? rd_data_reg[MEM_W-1:Q_W] : '0;
                            v1_reg[1] <= rd_ok_reg ? rd_data_reg[Q_W-1:0] : '0;
                        end
                    endcase
                end
            end else begin
                fetch_cnt_reg <= '0;
            end

            if (state_reg == ST_MAC) begin
                mac_cnt_reg <= mac_cnt_reg + 3'd1;
            end else begin
                mac_cnt_reg <= '0;
            end

            if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end else begin
                div_cnt_reg <= '0;
            end

            if (state_reg == ST_PUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // waypoint memory, {position, velocity} per entry, shoulder then elbow
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {s_data.load_position, s_data.load_velocity};
        end
        rd_data_reg <= mem[mem_raddr];
        rd_ok_reg   <= int'(rd_idx) < MAX_POINTS;
        rd_sel_reg  <= fetch_cnt_reg[1:0];
    end

    // operand selection for the multiply-accumulate
    always_comb begin
        case (mac_cnt_reg)
            3'd0: begin
                coef_sel = c_reg[0];
                for (int l = 0; l < 2; l++) d_sel[l] = p0_reg[l];
            end
            3'd1: begin
                coef_sel = c_reg[1];
                for (int l = 0; l < 2; l++) d_sel[l] = p1_reg[l];
            end
            3'd2: begin
                coef_sel = c_reg[2];
                for (int l = 0; l < 2; l++) d_sel[l] = v0_reg[l];
            end
            3'd3: begin
                coef_sel = c_reg[3];
                for (int l = 0; l < 2; l++) d_sel[l] = v1_reg[l];
            end
            default: begin
                coef_sel = '0;
                for (int l = 0; l < 2; l++) d_sel[l] = '0;
            end
        endcase
    end

    // two quotient bits a cycle, restoring
    always_comb begin
        logic [DIV_W-1:0] r;
        logic [QUO_W-1:0] q;
        logic [DIV_W:0]   t;
        logic             b;
        for (int l = 0; l < 2; l++) begin
            r = rem_reg[l];
            q = quo_reg[l];
            for (int s = 0; s < DIV_STEPS; s++) begin
                t = {r, q[QUO_W-1]};
                if (t >= {1'b0, dvs_w}) begin
                    r = DIV_W'(t - {1'b0, dvs_w});
                    b = 1'b1;
                end else begin
                    r = t[DIV_W-1:0];
                    b = 1'b0;
                end
                q = {q[QUO_W-2:0], b};
            end
            rem_next[l] = r;
            quo_next[l] = q;
        end
    end

    // rounding result back to signed and saturated
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (!neg_reg[l]) begin
                cmd_sat[l] = (ovf_reg[l] || quo_reg[l][QUO_W-1]) ? Q_MAX
                                                                  : $signed(quo_reg[l]);
            end else if (ovf_reg[l] || quo_reg[l] > 24'h800000) begin
                cmd_sat[l] = Q_MIN;
            end else begin
                cmd_sat[l] = $signed(Q_W'(24'd0 - quo_reg[l]));
            end
        end
    end

    // arithmetic datapath
    always_ff @(posedge aclk) begin
        if (tick_go) begin
            n_reg <= n_cur;
            k_reg <= k_cur;
        end

        if (state_reg == ST_IDLE && tick_go && k_cur == '0 && !can_latch) begin
            res_reg.shoulder_command <= p1_reg[0];
            res_reg.elbow_command    <= p1_reg[1];
            res_reg.done_res         <= 1'b1;
        end

        if (state_reg == ST_SQUARE) begin
            msq_reg <= {8'd0, m_w} * {8'd0, m_w};
            ksq_reg <= {8'd0, k_reg} * {8'd0, k_reg};
            nsq_reg <= {8'd0, n_reg} * {8'd0, n_reg};
        end

        if (state_reg == ST_COEF) begin
            c_reg[0] <= COEF_W'(26'(a0_w) * 26'(msq_reg));
            c_reg[1] <= COEF_W'(26'(a1_w) * 26'(ksq_reg));
            c_reg[2] <= COEF_W'(24'(k_reg) * 24'(msq_reg));
            c_reg[3] <= COEF_W'(24'(m_w) * 24'(ksq_reg));
            den_reg  <= COEF_W'(24'(n_reg) * 24'(nsq_reg));
            for (int l = 0; l < 2; l++) acc_reg[l] <= '0;
        end

        if (state_reg == ST_MAC) begin
            prod_sub_reg <= (mac_cnt_reg == MAC_SUB);
            for (int l = 0; l < 2; l++) begin
                prod_reg[l] <= PROD_W'($signed({1'b0, coef_sel})) * PROD_W'(d_sel[l]);
                if (mac_cnt_reg != '0) begin
                    acc_reg[l] <= prod_sub_reg ? acc_reg[l] - ACC_W'(prod_reg[l])
                                               : acc_reg[l] + ACC_W'(prod_reg[l]);
                end
            end
        end

        // 2|num| + den, the rounding offset folded into one add
        if (state_reg == ST_DIVSET) begin
            for (int l = 0; l < 2; l++) begin
                neg_reg[l] <= acc_reg[l][ACC_W-1];
                x_reg[l]   <= acc_reg[l][ACC_W-1]
                            ? ACC_W'((ACC_W+1)'(den_reg) - {acc_reg[l], 1'b0})
                            : ACC_W'({acc_reg[l], 1'b0} + (ACC_W+1)'(den_reg));
            end
        end

        if (state_reg == ST_DIVCHK) begin
            for (int l = 0; l < 2; l++) begin
                ovf_reg[l] <= x_reg[l] >= ACC_W'({dvs_w, QUO_W'(0)});
                rem_reg[l] <= x_reg[l][DIV_W+QUO_W-1:QUO_W];
                quo_reg[l] <= x_reg[l][QUO_W-1:0];
            end
        end

        if (state_reg == ST_DIV) begin
            for (int l = 0; l < 2; l++) begin
                rem_reg[l] <= rem_next[l];
                quo_reg[l] <= quo_next[l];
            end
        end

        if (state_reg == ST_FINISH) begin
            res_reg.shoulder_command <= cmd_sat[0];
            res_reg.elbow_command    <= cmd_sat[1];
            res_reg.done_res         <= 1'b0;
        end

        if (state_reg == ST_PUT && out_free) begin
            m_data_reg <= res_reg;
        end
    end

endmodule
